### hw/rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Types, constants and helpers shared by the segment and page translator.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned GLOBAL_DEPTH    = 256;
  localparam int unsigned LOCAL_DEPTH     = 256;
  localparam int unsigned DIRECTORY_DEPTH = 1024;
  localparam int unsigned PAGE_DEPTH      = 1024;

  localparam int unsigned GLOBAL_AW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int unsigned LOCAL_AW  = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
  localparam int unsigned DIR_AW    = (DIRECTORY_DEPTH > 1) ? $clog2(DIRECTORY_DEPTH) : 1;
  localparam int unsigned PAGE_AW   = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;

  localparam int unsigned DESC_CNT_W = 9;
  localparam int unsigned PAGE_CNT_W = 11;
  localparam int unsigned LIM_W      = 14;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [2:0] OP_TRANSLATE   = 3'd0;
  localparam logic [2:0] OP_WRITE_GLOB  = 3'd1;
  localparam logic [2:0] OP_WRITE_LOCAL = 3'd2;
  localparam logic [2:0] OP_WRITE_DIR   = 3'd3;
  localparam logic [2:0] OP_WRITE_PAGE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_COUNT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_COUNT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 4'd3;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_INDEX       = 4'd1;
  localparam logic [3:0] ST_NULL        = 4'd2;
  localparam logic [3:0] ST_ABSENT      = 4'd3;
  localparam logic [3:0] ST_LIMIT       = 4'd4;
  localparam logic [3:0] ST_LINEAR      = 4'd5;
  localparam logic [3:0] ST_DIR         = 4'd6;
  localparam logic [3:0] ST_PAGE        = 4'd7;
  localparam logic [3:0] ST_PAGE_ABSENT = 4'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  entry_index;
    logic [63:0] entry_data;
    logic [31:0] logical_offset;
    logic [15:0] segment_selector;
  } in_item_t;

  typedef struct packed {
    logic [31:0] physical_address;
    logic [3:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  status;
    logic [9:0]  dir;
    logic [9:0]  page;
    logic [11:0] lin_low;
  } seg_res_t;

  function automatic logic [LIM_W-1:0] clamp_count(input logic [LIM_W-1:0] cnt,
                                                   input logic [LIM_W-1:0] depth);
    return (cnt > depth) ? depth : cnt;
  endfunction

endpackage

### hw/rtl/segment_and_page_translator.sv
// ----------------------------------------------------------------------------
// segment_and_page_translator
// Segment descriptor and two-level page translation of logical addresses.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   in       | start, busy          | in_item   (in_item_t)
//   out      | out_valid (strobe)   | out_item  (out_item_t)
//   cfg      | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// A write item leaves busy low.
// A translate item holds busy for one cycle (descriptor read), so the next item
// waits for busy to drop; the result strobes from the output register, behind
// the descriptor read and the directory and page table reads.
// Reset clears the count registers and the pipeline valid flags; table contents are kept.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module segment_and_page_translator
  import spt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  accept;
  logic                  do_translate;
  logic [DESC_CNT_W-1:0] global_count_r;
  logic [DESC_CNT_W-1:0] local_count_r;
  logic [PAGE_CNT_W-1:0] dir_count_r;
  logic [PAGE_CNT_W-1:0] page_count_r;
  seg_res_t              seg_res;

  assign cfg_ready    = 1'b1;
  assign accept       = start && !busy;
  assign do_translate = accept && (in_item.opcode == OP_TRANSLATE);
  assign busy         = seg_res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_count_r <= '0;
      local_count_r  <= '0;
      dir_count_r    <= '0;
      page_count_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GLOBAL_COUNT: global_count_r <= cfg_data[DESC_CNT_W-1:0];
        CFG_LOCAL_COUNT:  local_count_r  <= cfg_data[DESC_CNT_W-1:0];
        CFG_DIR_COUNT:    dir_count_r    <= cfg_data[PAGE_CNT_W-1:0];
        CFG_PAGE_COUNT:   page_count_r   <= cfg_data[PAGE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  spt_seg_unit u_seg (
    .clk          (clk),
    .rst_n        (rst_n),
    .translate    (do_translate),
    .wr_global    (accept && (in_item.opcode == OP_WRITE_GLOB)),
    .wr_local     (accept && (in_item.opcode == OP_WRITE_LOCAL)),
    .slot         (in_item.entry_index),
    .wr_data      (in_item.entry_data),
    .offset       (in_item.logical_offset),
    .selector     (in_item.segment_selector),
    .global_count (global_count_r),
    .local_count  (local_count_r),
    .seg_res      (seg_res)
  );

  spt_page_unit u_page (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_dir     (accept && (in_item.opcode == OP_WRITE_DIR)),
    .wr_page    (accept && (in_item.opcode == OP_WRITE_PAGE)),
    .slot       (in_item.entry_index),
    .wr_data    (in_item.entry_data[31:0]),
    .dir_count  (dir_count_r),
    .page_count (page_count_r),
    .seg_res    (seg_res),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  a_translate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    do_translate |=> busy)
    else $error("translate transfer did not raise busy");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("descriptor stage held for more than one cycle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ##1 out_valid)
    else $error("result strobe missing after descriptor stage");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> out_item.physical_address == 32'h0)
    else $error("faulting result carries a non-zero address");

endmodule

### hw/rtl/spt_ram.sv
// ----------------------------------------------------------------------------
// spt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/spt_seg_unit.sv
// ----------------------------------------------------------------------------
// spt_seg_unit
// Descriptor tables, selector checks and segment decode to a linear address.
// ----------------------------------------------------------------------------
module spt_seg_unit
  import spt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  translate,
  input  logic                  wr_global,
  input  logic                  wr_local,
  input  logic [9:0]            slot,
  input  logic [63:0]           wr_data,
  input  logic [31:0]           offset,
  input  logic [15:0]           selector,
  input  logic [DESC_CNT_W-1:0] global_count,
  input  logic [DESC_CNT_W-1:0] local_count,
  output seg_res_t              seg_res
);

  localparam logic [LIM_W-1:0] GDEPTH = LIM_W'(GLOBAL_DEPTH);
  localparam logic [LIM_W-1:0] LDEPTH = LIM_W'(LOCAL_DEPTH);

  logic                 sel_local;
  logic [12:0]          sel_idx;
  logic [LIM_W-1:0]     idx_lim;
  logic [3:0]           fault0;

  logic                 s1_valid_r;
  logic                 s1_local_r;
  logic [3:0]           s1_fault_r;
  logic [31:0]          s1_offset_r;

  logic [63:0]          gdesc;
  logic [63:0]          ldesc;
  logic [63:0]          desc;
  logic [31:0]          base;
  logic [31:0]          limit;
  logic                 gran;
  logic                 exp_down;
  logic [31:0]          off_cmp;
  logic                 lim_fault;
  logic [32:0]          linear;

  // selector checks at the transfer
  always_comb begin
    sel_local = selector[3];
    sel_idx   = selector[15:3];
    idx_lim   = sel_local ? clamp_count(LIM_W'(local_count), LDEPTH)
                          : clamp_count(LIM_W'(global_count), GDEPTH);
    priority if (LIM_W'(sel_idx) >= idx_lim) begin
      fault0 = ST_INDEX;
    end else if (sel_idx == 13'd0 && !sel_local) begin
      fault0 = ST_NULL;
    end else begin
      fault0 = ST_OK;
    end
  end

  spt_ram #(.WIDTH(64), .DEPTH(GLOBAL_DEPTH)) u_gdt (
    .clk     (clk),
    .wr_en   (wr_global && (LIM_W'(slot) < GDEPTH)),
    .wr_addr (GLOBAL_AW'(slot)),
    .wr_data (wr_data),
    .rd_en   (translate),
    .rd_addr (GLOBAL_AW'(sel_idx)),
    .rd_data (gdesc)
  );

  spt_ram #(.WIDTH(64), .DEPTH(LOCAL_DEPTH)) u_ldt (
    .clk     (clk),
    .wr_en   (wr_local && (LIM_W'(slot) < LDEPTH)),
    .wr_addr (LOCAL_AW'(slot)),
    .wr_data (wr_data),
    .rd_en   (translate),
    .rd_addr (LOCAL_AW'(sel_idx)),
    .rd_data (ldesc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= translate;
    end
  end

  always_ff @(posedge clk) begin
    if (translate) begin
      s1_local_r  <= sel_local;
      s1_fault_r  <= fault0;
      s1_offset_r <= offset;
    end
  end

  // descriptor decode and bound checks
  always_comb begin
    desc     = s1_local_r ? ldesc : gdesc;
    base     = {desc[63:56], desc[39:32], desc[31:16]};
    gran     = desc[55];
    limit    = gran ? {desc[51:48], desc[15:0], 12'h000} : {12'h000, desc[51:48], desc[15:0]};
    exp_down = desc[44] && desc[42];
    off_cmp  = gran ? {s1_offset_r[31:12], 12'h000} : s1_offset_r;
    lim_fault = exp_down ? (s1_offset_r < limit) : (off_cmp > limit);
    linear   = {1'b0, base} + {1'b0, s1_offset_r};

    seg_res.valid   = s1_valid_r;
    seg_res.dir     = linear[31:22];
    seg_res.page    = linear[21:12];
    seg_res.lin_low = linear[11:0];
    priority if (s1_fault_r != ST_OK) begin
      seg_res.status = s1_fault_r;
    end else if (!desc[47]) begin
      seg_res.status = ST_ABSENT;
    end else if (lim_fault) begin
      seg_res.status = ST_LIMIT;
    end else if (linear[32] || linear[31]) begin
      seg_res.status = ST_LINEAR;
    end else begin
      seg_res.status = ST_OK;
    end
  end

endmodule

### hw/rtl/spt_page_unit.sv
// ----------------------------------------------------------------------------
// spt_page_unit
// Page directory and page table, index checks and the physical address.
// ----------------------------------------------------------------------------
module spt_page_unit
  import spt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_dir,
  input  logic                  wr_page,
  input  logic [9:0]            slot,
  input  logic [31:0]           wr_data,
  input  logic [PAGE_CNT_W-1:0] dir_count,
  input  logic [PAGE_CNT_W-1:0] page_count,
  input  seg_res_t              seg_res,
  output logic                  out_valid,
  output out_item_t             out_item
);

  localparam logic [LIM_W-1:0] DDEPTH = LIM_W'(DIRECTORY_DEPTH);
  localparam logic [LIM_W-1:0] PDEPTH = LIM_W'(PAGE_DEPTH);

  logic [LIM_W-1:0] dir_lim;
  logic [LIM_W-1:0] page_lim;
  logic [3:0]       status1;
  logic [31:0]      pde;
  logic [31:0]      pte;

  logic             s2_valid_r;
  logic [3:0]       s2_status_r;
  logic [11:0]      s2_low_r;

  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;

  always_comb begin
    dir_lim  = clamp_count(LIM_W'(dir_count), DDEPTH);
    page_lim = clamp_count(LIM_W'(page_count), PDEPTH);
    priority if (seg_res.status != ST_OK) begin
      status1 = seg_res.status;
    end else if (LIM_W'(seg_res.dir) >= dir_lim) begin
      status1 = ST_DIR;
    end else if (LIM_W'(seg_res.page) >= page_lim) begin
      status1 = ST_PAGE;
    end else begin
      status1 = ST_OK;
    end
  end

  spt_ram #(.WIDTH(32), .DEPTH(DIRECTORY_DEPTH)) u_dir (
    .clk     (clk),
    .wr_en   (wr_dir && (LIM_W'(slot) < DDEPTH)),
    .wr_addr (DIR_AW'(slot)),
    .wr_data (wr_data),
    .rd_en   (seg_res.valid),
    .rd_addr (DIR_AW'(seg_res.dir)),
    .rd_data (pde)
  );

  spt_ram #(.WIDTH(32), .DEPTH(PAGE_DEPTH)) u_pt (
    .clk     (clk),
    .wr_en   (wr_page && (LIM_W'(slot) < PDEPTH)),
    .wr_addr (PAGE_AW'(slot)),
    .wr_data (wr_data),
    .rd_en   (seg_res.valid),
    .rd_addr (PAGE_AW'(seg_res.page)),
    .rd_data (pte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= seg_res.valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_res.valid) begin
      s2_status_r <= status1;
      s2_low_r    <= seg_res.lin_low;
    end
  end

  always_comb begin
    out_item_nxt.status           = s2_status_r;
    out_item_nxt.physical_address = 32'h0;
    if (s2_status_r == ST_OK) begin
      if (pde[0] && pte[0]) begin
        out_item_nxt.physical_address = {pte[31:12], s2_low_r};
      end else begin
        out_item_nxt.status = ST_PAGE_ABSENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks segment_and_page_translator against a predictor held in this file.
// Descriptor, directory and page entries are written through the item channel,
// translations are predicted at each transfer and every strobed result is
// compared in order. The count registers are set to several values between
// phases: zero, one, the table depths, values above the depths and random.
// ----------------------------------------------------------------------------
module testbench;
  import spt_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int unsigned TIMEOUT_CYCLES = 500000;

  class xlat_scoreboard;
    logic [63:0] gdt  [GLOBAL_DEPTH];
    logic [63:0] ldt  [LOCAL_DEPTH];
    logic [31:0] pdir [DIRECTORY_DEPTH];
    logic [31:0] ptab [PAGE_DEPTH];
    bit g_seen [GLOBAL_DEPTH];
    bit l_seen [LOCAL_DEPTH];
    bit d_seen [DIRECTORY_DEPTH];
    bit p_seen [PAGE_DEPTH];
    logic [8:0]  gcount;
    logic [8:0]  lcount;
    logic [10:0] dcount;
    logic [10:0] pcount;
    out_item_t awaited [$];
    int errors;
    int checked;
    int clean;
    int faulted;

    function new();
      gcount = '0;
      lcount = '0;
      dcount = '0;
      pcount = '0;
    endfunction

    static function int unsigned bounded(int unsigned cnt, int unsigned depth);
      return (cnt > depth) ? depth : cnt;
    endfunction

    function int unsigned span(bit loc);
      return loc ? bounded(lcount, LOCAL_DEPTH) : bounded(gcount, GLOBAL_DEPTH);
    endfunction

    function void set_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GLOBAL_COUNT: gcount = val[8:0];
        CFG_LOCAL_COUNT:  lcount = val[8:0];
        CFG_DIR_COUNT:    dcount = val[10:0];
        CFG_PAGE_COUNT:   pcount = val[10:0];
        default: ;
      endcase
    endfunction

    // Walk descriptor, directory and page table; flag the first unwritten read.
    function logic [3:0] walk(input logic [31:0] offset, input logic [15:0] sel,
                              output logic [31:0] phys, output bit miss,
                              output logic [2:0] miss_op, output logic [9:0] miss_slot);
      bit loc;
      bit gran;
      int unsigned idx;
      logic [63:0] d;
      logic [31:0] base;
      logic [31:0] lim;
      logic [31:0] cmp_off;
      logic [32:0] lo;
      logic [32:0] hi;
      logic [32:0] lin;
      logic [9:0] di;
      logic [9:0] pi;
      phys = '0;
      miss = 1'b0;
      miss_op = OP_TRANSLATE;
      miss_slot = '0;
      loc = sel[3];
      idx = sel[15:3];
      if (idx >= span(loc)) return ST_INDEX;
      if (idx == 0 && !loc) return ST_NULL;
      if (loc ? !l_seen[idx] : !g_seen[idx]) begin
        miss = 1'b1;
        miss_op = loc ? OP_WRITE_LOCAL : OP_WRITE_GLOB;
        miss_slot = idx[9:0];
        return ST_OK;
      end
      d = loc ? ldt[idx] : gdt[idx];
      if (!d[47]) return ST_ABSENT;
      base = {d[63:56], d[39:32], d[31:16]};
      lim = {12'h000, d[51:48], d[15:0]};
      gran = d[55];
      if (gran) lim = lim << 12;
      if (d[44] && d[42]) begin
        lo = {1'b0, lim};
        hi = 33'h0_FFFF_FFFF;
      end else begin
        lo = '0;
        hi = {1'b0, lim};
      end
      cmp_off = gran ? {offset[31:12], 12'h000} : offset;
      if ({1'b0, cmp_off} > hi || {1'b0, offset} < lo) return ST_LIMIT;
      lin = {1'b0, base} + {1'b0, offset};
      if (lin > 33'h0_7FFF_FFFF) return ST_LINEAR;
      di = lin[31:22];
      pi = lin[21:12];
      if (di >= bounded(dcount, DIRECTORY_DEPTH)) return ST_DIR;
      if (pi >= bounded(pcount, PAGE_DEPTH)) return ST_PAGE;
      if (!d_seen[di] || !p_seen[pi]) begin
        miss = 1'b1;
        miss_op = d_seen[di] ? OP_WRITE_PAGE : OP_WRITE_DIR;
        miss_slot = d_seen[di] ? pi : di;
        return ST_OK;
      end
      if (!pdir[di][0] || !ptab[pi][0]) return ST_PAGE_ABSENT;
      phys = {ptab[pi][31:12], lin[11:0]};
      return ST_OK;
    endfunction

    function void note(in_item_t it);
      out_item_t want;
      bit miss;
      logic [2:0] op;
      logic [9:0] slot;
      case (it.opcode)
        OP_TRANSLATE: begin
          want.status = walk(it.logical_offset, it.segment_selector,
                             want.physical_address, miss, op, slot);
          awaited.push_back(want);
          if (want.status == ST_OK) clean++;
          else faulted++;
        end
        OP_WRITE_GLOB:
          if (it.entry_index < GLOBAL_DEPTH) begin
            gdt[it.entry_index] = it.entry_data;
            g_seen[it.entry_index] = 1'b1;
          end
        OP_WRITE_LOCAL:
          if (it.entry_index < LOCAL_DEPTH) begin
            ldt[it.entry_index] = it.entry_data;
            l_seen[it.entry_index] = 1'b1;
          end
        OP_WRITE_DIR:
          if (it.entry_index < DIRECTORY_DEPTH) begin
            pdir[it.entry_index] = it.entry_data[31:0];
            d_seen[it.entry_index] = 1'b1;
          end
        OP_WRITE_PAGE:
          if (it.entry_index < PAGE_DEPTH) begin
            ptab[it.entry_index] = it.entry_data[31:0];
            p_seen[it.entry_index] = 1'b1;
          end
        default: ;
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: phys %h status %0d", got.physical_address, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.physical_address !== want.physical_address || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected phys %h status %0d, got phys %h status %0d",
                   want.physical_address, want.status, got.physical_address, got.status);
      end
    endfunction

    function void close();
      if (awaited.size() != 0) begin
        $display("missing results: %0d", awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  xlat_scoreboard sb;
  int sent;
  int settings;
  int calm_left;

  segment_and_page_translator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_item);
  end

  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(39, 0) == 0) calm_left = $urandom_range(40, 10);
    return $urandom_range(16, 0);
  endfunction

  function automatic logic [63:0] make_desc(input logic [31:0] base, input logic [19:0] lim,
                                            input bit gran, input bit down, input bit present);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[63:56] = base[31:24];
    d[39:32] = base[23:16];
    d[31:16] = base[15:0];
    d[51:48] = lim[19:16];
    d[15:0]  = lim[15:0];
    d[55] = gran;
    d[47] = present;
    if (down) begin
      d[44] = 1'b1;
      d[42] = 1'b1;
    end else if (d[44] && d[42]) begin
      d[42] = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [63:0] rand_desc();
    logic [31:0] base;
    int unsigned pick;
    pick = $urandom_range(3, 0);
    base = (pick == 0) ? 32'h0 : (pick == 1) ? $urandom : {8'h00, 24'($urandom)};
    return make_desc(base, 20'($urandom), 1'($urandom), $urandom_range(4, 0) == 0,
                     $urandom_range(9, 0) != 0);
  endfunction

  function automatic logic [63:0] rand_page_entry();
    logic [63:0] e;
    e = {$urandom, $urandom};
    e[0] = $urandom_range(9, 0) != 0;
    return e;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(it);
    sent++;
  endtask

  task automatic put(input logic [2:0] op, input logic [9:0] slot, input logic [63:0] data);
    in_item_t it;
    it.opcode = op;
    it.entry_index = slot;
    it.entry_data = data;
    it.logical_offset = $urandom;
    it.segment_selector = 16'($urandom);
    send(it);
  endtask

  // Fill any entry the translation would read before sending it.
  task automatic probe(input logic [15:0] sel, input logic [31:0] off);
    in_item_t it;
    bit miss;
    logic [2:0] op;
    logic [9:0] slot;
    logic [31:0] phys;
    it.opcode = OP_TRANSLATE;
    it.entry_index = 10'($urandom);
    it.entry_data = {$urandom, $urandom};
    it.logical_offset = off;
    it.segment_selector = sel;
    do begin
      void'(sb.walk(off, sel, phys, miss, op, slot));
      if (miss)
        put(op, slot, (op == OP_WRITE_GLOB || op == OP_WRITE_LOCAL) ? rand_desc()
                                                                  : rand_page_entry());
    end while (miss);
    send(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_counts(input int unsigned g, input int unsigned l,
                                input int unsigned d, input int unsigned p);
    int unsigned vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    vals = '{g, l, d, p};
    regs = '{CFG_GLOBAL_COUNT, CFG_LOCAL_COUNT, CFG_DIR_COUNT, CFG_PAGE_COUNT};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_count(regs[i], CFG_DATA_W'(vals[i]));
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] sel_of(input int unsigned idx);
    return {idx[12:0], 3'($urandom)};
  endfunction

  // Mostly in-range selectors with offsets near or inside the segment bounds.
  task automatic random_translate();
    bit loc;
    int unsigned cnt;
    int unsigned idx;
    int unsigned base;
    int unsigned room;
    int unsigned lo;
    int unsigned hi;
    int unsigned brink;
    logic [63:0] d;
    logic [15:0] sel;
    logic [31:0] off;
    loc = $urandom_range(1, 0);
    cnt = sb.span(loc);
    if (cnt > 0 && $urandom_range(3, 0) != 0) begin
      idx = $urandom_range(cnt - 1, 0);
      idx[0] = loc;
    end else begin
      idx = $urandom_range(8191, 0);
    end
    sel = sel_of(idx);
    loc = sel[3];
    off = $urandom;
    if (idx < sb.span(loc) && (loc || idx != 0)) begin
      if (loc ? !sb.l_seen[idx] : !sb.g_seen[idx])
        put(loc ? OP_WRITE_LOCAL : OP_WRITE_GLOB, idx[9:0], rand_desc());
      d = loc ? sb.ldt[idx] : sb.gdt[idx];
      base = {d[63:56], d[39:32], d[31:16]};
      lo = {d[51:48], d[15:0]};
      if (d[55]) lo = lo << 12;
      room = (base > 32'h7FFF_FFFF) ? 0 : 32'h7FFF_FFFF - base;
      if (d[44] && d[42]) begin
        brink = lo;
        hi = room;
      end else begin
        brink = d[55] ? lo + 32'hFFF : lo;
        hi = (brink < room) ? brink : room;
        lo = 0;
      end
      case ($urandom_range(4, 0))
        0: ;
        1, 2: off = (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
        default: off = brink + $urandom_range(4, 0) - 2;
      endcase
    end
    probe(sel, off);
  endtask

  task automatic run_phase(input int n);
    in_item_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        random_translate();
      end else if (pick < 75) begin
        put($urandom_range(1, 0) ? OP_WRITE_LOCAL : OP_WRITE_GLOB,
            ($urandom_range(4, 0) == 0) ? 10'($urandom) : 10'($urandom_range(255, 0)),
            ($urandom_range(7, 0) == 0) ? {$urandom, $urandom} : rand_desc());
      end else if (pick < 95) begin
        put($urandom_range(1, 0) ? OP_WRITE_DIR : OP_WRITE_PAGE, 10'($urandom),
            rand_page_entry());
      end else begin
        it.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        it.entry_index = 10'($urandom);
        it.entry_data = {$urandom, $urandom};
        it.logical_offset = $urandom;
        it.segment_selector = 16'($urandom);
        send(it);
      end
    end
    settle();
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb = new();
    sent = 0;
    settings = 0;
    calm_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GLOBAL_COUNT;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty tables: extreme data, slots beyond depth, spare opcodes
    program_counts(0, 0, 0, 0);
    put(OP_WRITE_GLOB, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    put(OP_WRITE_LOCAL, 10'd0, 64'h0);
    put(OP_WRITE_GLOB, 10'd300, rand_desc());
    put(OP_WRITE_LOCAL, 10'd1023, rand_desc());
    probe(16'h0008, 32'h0);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      put(3'(op), 10'($urandom), {$urandom, $urandom});
    settle();

    // full tables: null, absent, limits, granularity, expand-down, ceiling
    program_counts(GLOBAL_DEPTH, LOCAL_DEPTH, DIRECTORY_DEPTH, PAGE_DEPTH);
    probe(16'h0000, 32'h0);
    probe(16'h0007, 32'hFFFF_FFFF);
    put(OP_WRITE_GLOB, 10'd2, make_desc(32'h0, 20'hFFFFF, 1'b0, 1'b0, 1'b0));
    probe(sel_of(2), 32'h0);
    put(OP_WRITE_LOCAL, 10'd1, make_desc(32'h1000, 20'h00FFF, 1'b0, 1'b0, 1'b1));
    put(OP_WRITE_DIR, 10'd0, 64'h1);
    put(OP_WRITE_PAGE, 10'd1, 64'hABCDE001);
    probe(sel_of(1), 32'h1000);
    probe(sel_of(1), 32'h0FFF);
    put(OP_WRITE_GLOB, 10'd4, make_desc(32'h0, 20'h00001, 1'b1, 1'b0, 1'b1));
    probe(sel_of(4), 32'h1FFF);
    probe(sel_of(4), 32'h2000);
    put(OP_WRITE_GLOB, 10'd6, make_desc(32'h0, 20'hFFFFF, 1'b1, 1'b0, 1'b1));
    probe(sel_of(6), 32'hFFFF_FFFF);
    put(OP_WRITE_LOCAL, 10'd3, make_desc(32'h0, 20'h00100, 1'b0, 1'b1, 1'b1));
    probe(sel_of(3), 32'h0FF);
    probe(sel_of(3), 32'h100);
    put(OP_WRITE_GLOB, 10'd8, make_desc(32'h2000, 20'hFFFFF, 1'b0, 1'b0, 1'b1));
    put(OP_WRITE_PAGE, 10'd2, 64'h2000);
    probe(sel_of(8), 32'h0);
    settle();

    // short tables: page beyond, directory beyond, index beyond
    program_counts(10, 4, 1, 2);
    probe(sel_of(8), 32'h0);
    probe(sel_of(6), 32'h0040_0000);
    probe(sel_of(10), 32'h0);
    settle();

    program_counts(GLOBAL_DEPTH, LOCAL_DEPTH, DIRECTORY_DEPTH, PAGE_DEPTH);
    run_phase(400);
    program_counts(511, 511, 2047, 2047);
    run_phase(300);
    program_counts(1, 1, 1, 1);
    run_phase(80);
    program_counts(0, 0, 0, 0);
    run_phase(40);
    for (int k = 0; k < 3; k++) begin
      program_counts($urandom_range(GLOBAL_DEPTH, 0), $urandom_range(LOCAL_DEPTH, 0),
                     $urandom_range(DIRECTORY_DEPTH, 0), $urandom_range(PAGE_DEPTH, 0));
      run_phase(230);
    end

    sb.close();
    $display("summary: %0d items transferred under %0d count settings, %0d results checked",
             sent, settings, sb.checked);
    $display("summary: %0d translations completed, %0d ended in a fault status",
             sb.clean, sb.faulted);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("errors: %0d", sb.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/spt_pkg.sv
hw/rtl/spt_ram.sv
hw/rtl/spt_seg_unit.sv
hw/rtl/spt_page_unit.sv
hw/rtl/segment_and_page_translator.sv
tb/sv/testbench.sv
